// ===== rtl/life_cellular_automaton_grid_macros.svh =====
// ----------------------------------------------------------------------------
// Life grid assertion macros
// Shared property templates for the grid engine checks.
// ----------------------------------------------------------------------------
`ifndef LIFE_CELLULAR_AUTOMATON_GRID_MACROS_SVH
`define LIFE_CELLULAR_AUTOMATON_GRID_MACROS_SVH

// same-cycle implication
`define LCAG_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LCAG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/lcag_pkg.sv =====
// ----------------------------------------------------------------------------
// Life grid package
// Opcodes, register indexes, command bundle and fixed field widths.
// ----------------------------------------------------------------------------
package lcag_pkg;

  localparam int OP_W    = 2;
  localparam int COORD_W = 6;
  localparam int CFG_W   = 7;
  localparam int IDX_W   = 2;
  localparam int GEN_W   = 32;
  localparam int ASH_W   = 13;

  localparam logic [ASH_W-1:0] ASH_LIMIT = 13'd8191;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE   = 2'd0,
    OP_READ    = 2'd1,
    OP_ADVANCE = 2'd2,
    OP_CLEAR   = 2'd3
  } opcode_t;

  localparam logic [IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;
  localparam logic [IDX_W-1:0] CFG_WRAP_MODE   = 2'd2;

  // what enters the row window during a generation sweep
  typedef enum logic [1:0] {
    SRC_ZERO = 2'd0,
    SRC_MEM  = 2'd1,
    SRC_ROW0 = 2'd2
  } push_src_t;

  typedef struct packed {
    logic      load;
    logic      rd_en;
    logic      addr_op;
    logic      wr_zero_live;
    logic      wr_zero_ash;
    logic      cell_wr;
    logic      clear_cnt;
    logic      adv_start;
    logic      push;
    push_src_t push_src;
    logic      save_row0;
    logic      eval;
    logic      report;
  } cmd_t;

endpackage

// ===== rtl/lcag_life_row.sv =====
// ----------------------------------------------------------------------------
// Life grid row rule
// Next state of one row from the rows above, at and below (B3/S23).
// ----------------------------------------------------------------------------
module lcag_life_row #(
  parameter int W = 64
) (
  input  logic [W-1:0]               top,
  input  logic [W-1:0]               mid,
  input  logic [W-1:0]               bot,
  input  logic [lcag_pkg::CFG_W-1:0] width,
  input  logic                       wrap,
  output logic [W-1:0]               next
);
  import lcag_pkg::*;

  localparam int CW = (W > 1) ? $clog2(W) : 1;

  logic [W-1:0]  mask;
  logic [W-1:0]  mt, mm, mb;
  logic [W-1:0]  lt, lm, lb;
  logic [W-1:0]  rt, rm, rb;
  logic [W-1:0]  last_bit;
  logic [CW-1:0] last_col;

  always_comb begin
    last_col = CW'(width - 7'd1);
    for (int x = 0; x < W; x++) begin
      mask[x] = (CFG_W'(x) < width);
    end
    mt = top & mask;
    mm = mid & mask;
    mb = bot & mask;
    last_bit = W'(1) << last_col;
    // horizontal neighbors, wrapping at the active width on a torus
    lt = (mt << 1) | ((wrap && mt[last_col]) ? W'(1) : '0);
    lm = (mm << 1) | ((wrap && mm[last_col]) ? W'(1) : '0);
    lb = (mb << 1) | ((wrap && mb[last_col]) ? W'(1) : '0);
    rt = (mt >> 1) | ((wrap && mt[0]) ? last_bit : '0);
    rm = (mm >> 1) | ((wrap && mm[0]) ? last_bit : '0);
    rb = (mb >> 1) | ((wrap && mb[0]) ? last_bit : '0);
  end

  always_comb begin
    logic [3:0] n;
    n = '0;
    for (int x = 0; x < W; x++) begin
      n = 4'(lt[x]) + 4'(mt[x]) + 4'(rt[x]) + 4'(lm[x]) + 4'(rm[x])
        + 4'(lb[x]) + 4'(mb[x]) + 4'(rb[x]);
      next[x] = mask[x] && ((n == 4'd3) || (mm[x] && (n == 4'd2)));
    end
  end

endmodule

// ===== rtl/lcag_datapath.sv =====
// ----------------------------------------------------------------------------
// Life grid datapath
// Live and ash row memories, sweep window, rule pipeline and counters.
// ----------------------------------------------------------------------------
module lcag_datapath #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic                                               clk,
  input  logic                                               rst,
  input  lcag_pkg::cmd_t                                     cmd,
  input  logic [((MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1)-1:0] row_addr,
  input  logic [lcag_pkg::CFG_W-1:0]                         eff_w,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]                    eff_h,
  input  logic                                               wrap,
  input  logic [lcag_pkg::COORD_W-1:0]                       col,
  input  logic [lcag_pkg::COORD_W-1:0]                       row,
  input  logic                                               alive_value,
  output logic                                               done,
  output logic                                               cell_alive,
  output logic                                               cell_ashed,
  output logic [lcag_pkg::GEN_W-1:0]                         generation,
  output logic [lcag_pkg::ASH_W-1:0]                         ash_count
);
  import lcag_pkg::*;

  localparam int CW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int NG   = (MAX_WIDTH + 7) / 8;
  localparam int PADW = NG * 8;

  function automatic logic [3:0] pop8(input logic [7:0] v);
    logic [3:0] c;
    c = '0;
    for (int b = 0; b < 8; b++) begin
      c = c + 4'(v[b]);
    end
    return c;
  endfunction

  logic [MAX_WIDTH-1:0] live_mem [MAX_HEIGHT];
  logic [MAX_WIDTH-1:0] ash_mem  [MAX_HEIGHT];
  logic [MAX_WIDTH-1:0] live_q, ash_q;
  logic [RW-1:0]        rd_addr;

  logic [CW-1:0] op_col;
  logic [RW-1:0] op_row;
  logic          op_val;

  logic          push_d, save_d, eval_d;
  push_src_t     src_d;
  logic [MAX_WIDTH-1:0] win_top, win_mid, win_bot, push_val;
  logic [MAX_WIDTH-1:0] ash_mid, ash_bot, row0_q;
  logic          eval_w, eval_n;
  logic [MAX_WIDTH-1:0] new_row, new_n, ash_n;
  logic [RW-1:0] y_wr;

  logic [PADW-1:0] newly_pad;
  logic [3:0]      grp_cnt [NG];
  logic            cnt_v;
  logic [6:0]      add_sum;
  logic [ASH_W:0]  sum_wide;

  logic [GEN_W-1:0] gen;
  logic [ASH_W-1:0] total;

  logic                 wr_live_en, wr_ash_en;
  logic [RW-1:0]        wr_addr;
  logic [MAX_WIDTH-1:0] wr_live_data, wr_ash_data;
  logic [MAX_WIDTH-1:0] bitm;

  assign rd_addr = cmd.addr_op ? op_row : row_addr;
  assign bitm    = MAX_WIDTH'(1) << op_col;

  // operands, clamped into the active area
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_col <= (32'(col) >= 32'(eff_w)) ? CW'(eff_w - 7'd1) : CW'(col);
      op_row <= (32'(row) >= 32'(eff_h)) ? RW'(eff_h - 1'b1) : RW'(row);
      op_val <= alive_value;
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      live_q <= live_mem[rd_addr];
      ash_q  <= ash_mem[rd_addr];
    end
    if (wr_live_en) begin
      live_mem[wr_addr] <= wr_live_data;
    end
    if (wr_ash_en) begin
      ash_mem[wr_addr] <= wr_ash_data;
    end
  end

  always_comb begin
    if (eval_n) begin
      wr_addr      = y_wr;
      wr_live_data = new_n;
      wr_ash_data  = ash_n | new_n;
      wr_live_en   = 1'b1;
      wr_ash_en    = 1'b1;
    end else if (cmd.cell_wr) begin
      wr_addr      = op_row;
      wr_live_data = (live_q & ~bitm) | (op_val ? bitm : '0);
      wr_ash_data  = ash_q | bitm;
      wr_live_en   = 1'b1;
      wr_ash_en    = 1'b1;
    end else begin
      wr_addr      = row_addr;
      wr_live_data = '0;
      wr_ash_data  = '0;
      wr_live_en   = cmd.wr_zero_live;
      wr_ash_en    = cmd.wr_zero_ash;
    end
  end

  // sweep window: read data lands in the cycle after the command
  always_comb begin
    case (src_d)
      SRC_MEM:  push_val = live_q;
      SRC_ROW0: push_val = row0_q;
      default:  push_val = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      push_d <= 1'b0;
      eval_d <= 1'b0;
      eval_w <= 1'b0;
      eval_n <= 1'b0;
      cnt_v  <= 1'b0;
    end else begin
      push_d <= cmd.push;
      eval_d <= cmd.eval;
      eval_w <= push_d && eval_d;
      eval_n <= eval_w;
      cnt_v  <= eval_n;
    end
  end

  always_ff @(posedge clk) begin
    src_d  <= cmd.push_src;
    save_d <= cmd.save_row0;
    if (push_d) begin
      win_top <= win_mid;
      win_mid <= win_bot;
      win_bot <= push_val;
      ash_mid <= ash_bot;
      ash_bot <= ash_q;
      if (save_d) begin
        row0_q <= live_q;
      end
    end
    if (eval_w) begin
      new_n <= new_row;
      ash_n <= ash_mid;
    end
    if (cmd.adv_start) begin
      y_wr <= '0;
    end else if (eval_n) begin
      y_wr <= y_wr + 1'b1;
    end
  end

  lcag_life_row #(
    .W (MAX_WIDTH)
  ) u_rule (
    .top   (win_top),
    .mid   (win_mid),
    .bot   (win_bot),
    .width (eff_w),
    .wrap  (wrap),
    .next  (new_row)
  );

  // newly ashed cells: per-byte counts, then summed into the total
  assign newly_pad = PADW'(new_n & ~ash_n);

  always_ff @(posedge clk) begin
    for (int g = 0; g < NG; g++) begin
      grp_cnt[g] <= pop8(newly_pad[g*8 +: 8]);
    end
  end

  always_comb begin
    add_sum = '0;
    for (int g = 0; g < NG; g++) begin
      add_sum = add_sum + 7'(grp_cnt[g]);
    end
    sum_wide = {1'b0, total} + (ASH_W+1)'(add_sum);
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_cnt) begin
      gen   <= '0;
      total <= '0;
    end else begin
      if (cmd.adv_start) begin
        gen <= gen + 1'b1;
      end
      if (cmd.cell_wr && !ash_q[op_col]) begin
        if (total != ASH_LIMIT) begin
          total <= total + 1'b1;
        end
      end else if (cnt_v) begin
        total <= (sum_wide > {1'b0, ASH_LIMIT}) ? ASH_LIMIT : sum_wide[ASH_W-1:0];
      end
    end
  end

  // result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.report;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.report) begin
      cell_alive <= live_q[op_col];
      cell_ashed <= ash_q[op_col];
      generation <= gen;
      ash_count  <= total;
    end
  end

endmodule

// ===== rtl/lcag_ctrl.sv =====
// ----------------------------------------------------------------------------
// Life grid controller
// Sequences clear, cell access and generation sweeps over the row memories.
// ----------------------------------------------------------------------------
module lcag_ctrl #(
  parameter int MAX_HEIGHT = 64
) (
  input  logic                                               clk,
  input  logic                                               rst,
  input  logic                                               start,
  input  logic [lcag_pkg::OP_W-1:0]                          opcode,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]                    eff_h,
  input  logic                                               wrap,
  output logic                                               busy,
  output lcag_pkg::cmd_t                                     cmd,
  output logic [((MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1)-1:0] row_addr
);
  import lcag_pkg::*;

  localparam int RW           = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int CNTW         = $clog2(MAX_HEIGHT + 2);
  localparam int DRAIN_CYCLES = 4;

  typedef enum logic [8:0] {
    S_IDLE      = 9'b000000001,
    S_CLEAR     = 9'b000000010,
    S_CELL_RD   = 9'b000000100,
    S_CELL_WR   = 9'b000001000,
    S_ADV       = 9'b000010000,
    S_DRAIN     = 9'b000100000,
    S_FILL      = 9'b001000000,
    S_REPORT_RD = 9'b010000000,
    S_DONE      = 9'b100000000
  } state_t;

  state_t          state, state_next;
  logic [CNTW-1:0] cnt, cnt_next;
  logic            reply, reply_next;
  logic [CNTW-1:0] h_ext, last_row;

  assign h_ext    = CNTW'(eff_h);
  assign last_row = CNTW'(MAX_HEIGHT - 1);
  assign busy     = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    reply_next = reply;
    cmd        = '0;
    row_addr   = RW'(cnt);
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          reply_next = 1'b1;
          cnt_next   = '0;
          case (opcode_t'(opcode))
            OP_WRITE:   state_next = S_CELL_RD;
            OP_READ:    state_next = S_REPORT_RD;
            OP_ADVANCE: state_next = S_ADV;
            OP_CLEAR:   state_next = S_CLEAR;
            default:    state_next = S_REPORT_RD;
          endcase
        end
      end
      S_CLEAR: begin
        cmd.wr_zero_live = 1'b1;
        cmd.wr_zero_ash  = 1'b1;
        cmd.clear_cnt    = 1'b1;
        if (cnt == last_row) begin
          cnt_next   = '0;
          state_next = reply ? S_REPORT_RD : S_IDLE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_CELL_RD: begin
        cmd.rd_en   = 1'b1;
        cmd.addr_op = 1'b1;
        state_next  = S_CELL_WR;
      end
      S_CELL_WR: begin
        cmd.cell_wr = 1'b1;
        state_next  = S_REPORT_RD;
      end
      S_ADV: begin
        // window stream: row above row 0, rows 0..h-1, row below row h-1
        cmd.push = 1'b1;
        if (cnt == '0) begin
          cmd.adv_start = 1'b1;
          cmd.rd_en     = wrap;
          row_addr      = RW'(h_ext - 1'b1);
          cmd.push_src  = wrap ? SRC_MEM : SRC_ZERO;
        end else if (cnt == h_ext + 1'b1) begin
          cmd.eval     = 1'b1;
          cmd.push_src = wrap ? SRC_ROW0 : SRC_ZERO;
        end else begin
          cmd.rd_en     = 1'b1;
          row_addr      = RW'(cnt - 1'b1);
          cmd.push_src  = SRC_MEM;
          cmd.save_row0 = (cnt == CNTW'(1));
          cmd.eval      = (cnt >= CNTW'(2));
        end
        if (cnt == h_ext + 1'b1) begin
          cnt_next   = '0;
          state_next = S_DRAIN;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_DRAIN: begin
        if (cnt == CNTW'(DRAIN_CYCLES - 1)) begin
          if (h_ext == CNTW'(MAX_HEIGHT)) begin
            state_next = S_REPORT_RD;
          end else begin
            cnt_next   = h_ext;
            state_next = S_FILL;
          end
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_FILL: begin
        // rows past the active height die; their ash stays
        cmd.wr_zero_live = 1'b1;
        if (cnt == last_row) begin
          state_next = S_REPORT_RD;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_REPORT_RD: begin
        cmd.rd_en   = 1'b1;
        cmd.addr_op = 1'b1;
        state_next  = S_DONE;
      end
      S_DONE: begin
        cmd.report = 1'b1;
        reply_next = 1'b0;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      cnt   <= '0;
      reply <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      reply <= reply_next;
    end
  end

endmodule

// ===== rtl/life_cellular_automaton_grid.sv =====
// ----------------------------------------------------------------------------
// Life grid engine
// B3/S23 cell grid with an ash map, generation and ash counters.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: an item (opcode, col, row, alive_value) is taken on a
//   clock edge with start high and busy low. One result beat per item comes
//   back on done with cell_alive, cell_ashed, generation and ash_count; it
//   lasts one cycle and cannot be held off.
//   One item is in flight at a time; the next can be taken in the done
//   cycle. The generation sweep moves one row per cycle through the single
//   read and write port of each row memory, then zeroes the live rows past
//   the active height, so its length follows MAX_HEIGHT.
//   Configuration: cfg_write with cfg_index and cfg_data, only while idle.
//   Reset: a clearing pass zeroes both row memories; busy stays high
//   through it. Configuration writes are taken as usual.
// ----------------------------------------------------------------------------
`include "life_cellular_automaton_grid_macros.svh"

module life_cellular_automaton_grid #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [lcag_pkg::OP_W-1:0]    opcode,
  input  logic [lcag_pkg::COORD_W-1:0] col,
  input  logic [lcag_pkg::COORD_W-1:0] row,
  input  logic                         alive_value,
  output logic                         done,
  output logic                         cell_alive,
  output logic                         cell_ashed,
  output logic [lcag_pkg::GEN_W-1:0]   generation,
  output logic [lcag_pkg::ASH_W-1:0]   ash_count,
  input  logic                         cfg_write,
  input  logic [lcag_pkg::IDX_W-1:0]   cfg_index,
  input  logic [lcag_pkg::CFG_W-1:0]   cfg_data
);
  import lcag_pkg::*;

  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  logic [CFG_W-1:0] grid_width, grid_height;
  logic             wrap_mode;
  logic [CFG_W-1:0] eff_w;
  logic [HW-1:0]    eff_h;
  cmd_t             cmd;
  logic [RW-1:0]    row_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= 7'd64;
      grid_height <= 7'd64;
      wrap_mode   <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_GRID_WIDTH:  grid_width  <= cfg_data;
        CFG_GRID_HEIGHT: grid_height <= cfg_data;
        CFG_WRAP_MODE:   wrap_mode   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // zero acts as one, anything above the maximum as the maximum
  always_comb begin
    if (grid_width == '0) begin
      eff_w = 7'd1;
    end else if (32'(grid_width) > MAX_WIDTH) begin
      eff_w = CFG_W'(MAX_WIDTH);
    end else begin
      eff_w = grid_width;
    end
    if (grid_height == '0) begin
      eff_h = HW'(1);
    end else if (32'(grid_height) > MAX_HEIGHT) begin
      eff_h = HW'(MAX_HEIGHT);
    end else begin
      eff_h = HW'(grid_height);
    end
  end

  lcag_ctrl #(
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .opcode   (opcode),
    .eff_h    (eff_h),
    .wrap     (wrap_mode),
    .busy     (busy),
    .cmd      (cmd),
    .row_addr (row_addr)
  );

  lcag_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .row_addr    (row_addr),
    .eff_w       (eff_w),
    .eff_h       (eff_h),
    .wrap        (wrap_mode),
    .col         (col),
    .row         (row),
    .alive_value (alive_value),
    .done        (done),
    .cell_alive  (cell_alive),
    .cell_ashed  (cell_ashed),
    .generation  (generation),
    .ash_count   (ash_count)
  );

  `LCAG_ASSERT_NEXT(a_accept_goes_busy, clk, rst, start && !busy, busy, "accept left block idle")
  `LCAG_ASSERT_SAME(a_done_after_busy, clk, rst, done, $past(busy), "result beat without work")
  `LCAG_ASSERT_NEXT(a_single_beat, clk, rst, done, !done, "result beat repeated")
  `LCAG_ASSERT_SAME(a_live_is_ashed, clk, rst, done && cell_alive, cell_ashed, "live without ash")

endmodule
